### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands, sampled on clk and off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/wpp_pkg.sv
// ----------------------------------------------------------------------------
// wpp_pkg
// Types and constants shared by the WAV PCM stream parser modules.
// ----------------------------------------------------------------------------
package wpp_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_CHDR,
        PH_SKIP,
        PH_FMT,
        PH_DATA,
        PH_PAD,
        PH_SINK
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK,
        ST_BADHDR,
        ST_NOTPCM,
        ST_BADBITS,
        ST_EMPTY,
        ST_TRUNC
    } status_t;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] sample;
        status_t            status;
        logic [15:0]        channel_count;
        logic [31:0]        rate_hz;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    typedef struct packed {
        logic    valid;
        result_t item;
    } head_t;

endpackage

### rtl/wav_pcm_stream_parser.sv
// Results of a byte are written into the result queue and then loaded into the output register.
// Throughput: one byte per cycle while in_ready is high; the end-of-file byte with
//   a sample yields two results, which leave one per cycle while out_ready is high.
// Input ready drops while the queue holds more than QUEUE_DEPTH-2 results.
// Reset (asynchronous, rst_n low) clears parser state, queue and output valid.
// ----------------------------------------------------------------------------
// wav_pcm_stream_parser
// RIFF/WAVE byte-stream parser emitting 16-bit PCM samples and a file report.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_pcm_stream_parser #(
    parameter int QUEUE_DEPTH = wpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         file_byte,
    input  logic               end_of_file,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [15:0] sample,
    output logic [2:0]         status,
    output logic [15:0]        channel_count,
    output logic [31:0]        rate_hz,
    output logic               last
);
    import wpp_pkg::*;

    push_t push;
    head_t head;
    logic  room;
    logic  pop;

    wpp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .file_byte   (file_byte),
        .end_of_file (end_of_file),
        .room        (room),
        .push        (push)
    );

    wpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .head  (head),
        .pop   (pop)
    );

    wpp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kind          (kind),
        .sample        (sample),
        .status        (status),
        .channel_count (channel_count),
        .rate_hz       (rate_hz),
        .last          (last)
    );

    `ASSERT_IMPLY(a_push_on_transfer, push.count != 2'd0, in_valid && in_ready,
        "push without input transfer")
    `ASSERT_IMPLY(a_eof_reports, in_valid && in_ready && end_of_file,
        (push.count == 2'd1 && push.first.kind == KIND_REPORT) ||
        (push.count == 2'd2 && push.second.kind == KIND_REPORT),
        "end of file without report")
    `ASSERT_IMPLY(a_pair_order, push.count == 2'd2,
        push.first.kind == KIND_SAMPLE && push.second.kind == KIND_REPORT,
        "result pair out of order")
    `ASSERT_IMPLY(a_pop_nonempty, pop, head.valid, "pop from empty queue")
    `ASSERT_NEXT(a_pop_loads, pop, out_valid, "popped result not presented")

endmodule

### rtl/wpp_queue.sv
// ----------------------------------------------------------------------------
// wpp_queue
// Result queue between parser and output stage: up to two writes, one read.
// ----------------------------------------------------------------------------
module wpp_queue #(
    parameter int DEPTH = wpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  wpp_pkg::push_t push,
    output logic           room,
    output wpp_pkg::head_t head,
    input  logic           pop
);
    import wpp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    result_t          mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [PW-1:0]    wr_ptr_one;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign wr_ptr_one = wrap_inc(wr_ptr_reg);
    assign room       = (count_reg <= CW'(DEPTH - 2));
    assign head.valid = (count_reg != '0);
    assign head.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        unique case (push.count)
            2'd1:    wr_ptr_next = wr_ptr_one;
            2'd2:    wr_ptr_next = wrap_inc(wr_ptr_one);
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem_reg[wr_ptr_one] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/wpp_front.sv
// ----------------------------------------------------------------------------
// wpp_front
// Byte parser: walks RIFF header and chunks, builds samples and the report.
// ----------------------------------------------------------------------------
module wpp_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  logic [7:0]     file_byte,
    input  logic           end_of_file,
    input  logic           room,
    output wpp_pkg::push_t push
);
    import wpp_pkg::*;

    phase_t       phase_reg, phase_next, phase_step, body_phase;
    logic [31:0]  offset_reg, offset_next, offset_inc;
    logic [31:0]  length_reg, length_next, len_hdr;
    logic [31:0]  tag_reg, tag_next, tag_shift;
    logic [15:0]  fmt_reg, fmt_next;
    logic [15:0]  chan_reg, chan_next;
    logic [31:0]  rate_reg, rate_next;
    logic [15:0]  bits_reg, bits_next;
    logic [7:0]   low_reg, low_next;
    logic         bad_reg, bad_next, bad_step;
    logic         data_reg, data_next;
    logic         emit_reg, emit_next;
    logic         play_reg, play_next;
    logic         playable;
    logic         fire;
    logic         smp_hit;
    logic [15:0]  smp_val;
    status_t      status_val;
    result_t      smp_item, rep_item;

    assign in_ready   = room;
    assign fire       = in_valid & room;
    assign tag_shift  = {tag_reg[23:0], file_byte};
    assign offset_inc = offset_reg + 32'd1;
    assign bad_step   = bad_reg | ((offset_reg == 32'd3) && (tag_shift != TAG_RIFF));
    assign playable   = (fmt_reg == 16'd1) && (chan_reg != '0) && (rate_reg != '0)
                        && ((bits_reg == 16'd8) || (bits_reg == 16'd16));

    always_comb
    begin
        len_hdr = length_reg;
        unique case (offset_reg[1:0])
            2'd0:    len_hdr = {24'd0, file_byte};
            2'd1:    len_hdr[15:8]  = file_byte;
            2'd2:    len_hdr[23:16] = file_byte;
            default: len_hdr[31:24] = file_byte;
        endcase
    end

    always_comb
    begin
        priority if (len_hdr == '0)
            body_phase = PH_CHDR;
        else if (tag_reg == TAG_DATA)
            body_phase = PH_DATA;
        else if ((tag_reg == TAG_FMT) && (len_hdr >= 32'd16) && !data_reg)
            body_phase = PH_FMT;
        else
            body_phase = PH_SKIP;
    end

    // next state
    always_comb
    begin
        phase_step = phase_reg;
        unique case (phase_reg)
            PH_HEADER:
            begin
                if (offset_reg == 32'd11)
                begin
                    phase_step = ((tag_shift != TAG_WAVE) || bad_step) ? PH_SINK : PH_CHDR;
                end
            end
            PH_CHDR:
            begin
                if (offset_reg == 32'd7)
                begin
                    phase_step = body_phase;
                end
            end
            PH_SKIP, PH_FMT, PH_DATA:
            begin
                if (offset_inc == length_reg)
                begin
                    phase_step = length_reg[0] ? PH_PAD : PH_CHDR;
                end
            end
            PH_PAD:  phase_step = PH_CHDR;
            default: phase_step = PH_SINK;
        endcase
        if (!fire)
            phase_next = phase_reg;
        else if (end_of_file)
            phase_next = PH_HEADER;
        else
            phase_next = phase_step;
    end

    // datapath and result pushes
    always_comb
    begin
        offset_next = offset_reg;
        length_next = length_reg;
        tag_next    = tag_reg;
        fmt_next    = fmt_reg;
        chan_next   = chan_reg;
        rate_next   = rate_reg;
        bits_next   = bits_reg;
        low_next    = low_reg;
        bad_next    = bad_reg;
        data_next   = data_reg;
        emit_next   = emit_reg;
        play_next   = play_reg;
        smp_hit     = 1'b0;
        smp_val     = '0;
        status_val  = ST_OK;
        smp_item    = '0;
        rep_item    = '0;
        push        = '0;

        if (fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if ((offset_reg < 32'd4) || (offset_reg >= 32'd8))
                    begin
                        tag_next = tag_shift;
                    end
                    bad_next    = bad_step;
                    offset_next = (offset_reg == 32'd11) ? '0 : offset_inc;
                end
                PH_CHDR:
                begin
                    if (offset_reg < 32'd4)
                        tag_next = tag_shift;
                    else
                        length_next = len_hdr;
                    if (offset_reg == 32'd7)
                    begin
                        offset_next = '0;
                        if (tag_reg == TAG_DATA)
                        begin
                            data_next = 1'b1;
                            play_next = playable;
                        end
                    end
                    else
                    begin
                        offset_next = offset_inc;
                    end
                end
                PH_SKIP, PH_FMT, PH_DATA:
                begin
                    if ((phase_reg == PH_FMT) && (offset_reg < 32'd16))
                    begin
                        unique case (offset_reg[3:0])
                            4'd0:    fmt_next[7:0]    = file_byte;
                            4'd1:    fmt_next[15:8]   = file_byte;
                            4'd2:    chan_next[7:0]   = file_byte;
                            4'd3:    chan_next[15:8]  = file_byte;
                            4'd4:    rate_next[7:0]   = file_byte;
                            4'd5:    rate_next[15:8]  = file_byte;
                            4'd6:    rate_next[23:16] = file_byte;
                            4'd7:    rate_next[31:24] = file_byte;
                            4'd14:   bits_next[7:0]   = file_byte;
                            4'd15:   bits_next[15:8]  = file_byte;
                            default: ;
                        endcase
                    end
                    else if ((phase_reg == PH_DATA) && play_reg)
                    begin
                        priority if (bits_reg == 16'd8)
                        begin
                            smp_hit = 1'b1;
                            smp_val = {file_byte ^ 8'h80, 8'h00};
                        end
                        else if (!offset_reg[0])
                        begin
                            low_next = file_byte;
                        end
                        else
                        begin
                            smp_hit = 1'b1;
                            smp_val = {file_byte, low_reg};
                        end
                    end
                    if (smp_hit)
                        emit_next = 1'b1;
                    offset_next = (offset_inc == length_reg) ? '0 : offset_inc;
                end
                PH_PAD:  offset_next = '0;
                default: ;
            endcase

            smp_item               = '0;
            smp_item.kind          = KIND_SAMPLE;
            smp_item.sample        = smp_val;
            if (smp_hit)
            begin
                push.count = 2'd1;
                push.first = smp_item;
            end

            if (end_of_file)
            begin
                priority if ((phase_step == PH_HEADER) || (phase_step == PH_SINK) || bad_next)
                    status_val = ST_BADHDR;
                else if ((fmt_next != 16'd1) || (chan_next == '0) || (rate_next == '0))
                    status_val = ST_NOTPCM;
                else if (!data_next)
                    status_val = ST_EMPTY;
                else if ((bits_next != 16'd8) && (bits_next != 16'd16))
                    status_val = ST_BADBITS;
                else if (phase_step == PH_DATA)
                    status_val = ST_TRUNC;
                else if (!emit_next)
                    status_val = ST_EMPTY;
                else
                    status_val = ST_OK;

                rep_item               = '0;
                rep_item.kind          = KIND_REPORT;
                rep_item.status        = status_val;
                rep_item.channel_count = chan_next;
                rep_item.rate_hz       = rate_next;
                if (smp_hit)
                begin
                    push.count  = 2'd2;
                    push.second = rep_item;
                end
                else
                begin
                    push.count = 2'd1;
                    push.first = rep_item;
                end

                offset_next = '0;
                length_next = '0;
                tag_next    = '0;
                fmt_next    = '0;
                chan_next   = '0;
                rate_next   = '0;
                bits_next   = '0;
                low_next    = '0;
                bad_next    = 1'b0;
                data_next   = 1'b0;
                emit_next   = 1'b0;
                play_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            length_reg <= '0;
            tag_reg    <= '0;
            fmt_reg    <= '0;
            chan_reg   <= '0;
            rate_reg   <= '0;
            bits_reg   <= '0;
            low_reg    <= '0;
            bad_reg    <= 1'b0;
            data_reg   <= 1'b0;
            emit_reg   <= 1'b0;
            play_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            length_reg <= length_next;
            tag_reg    <= tag_next;
            fmt_reg    <= fmt_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            low_reg    <= low_next;
            bad_reg    <= bad_next;
            data_reg   <= data_next;
            emit_reg   <= emit_next;
            play_reg   <= play_next;
        end
    end

endmodule

### rtl/wpp_back.sv
// ----------------------------------------------------------------------------
// wpp_back
// Output stage: takes results from the queue and holds them for transfer.
// ----------------------------------------------------------------------------
module wpp_back (
    input  logic               clk,
    input  logic               rst_n,
    input  wpp_pkg::head_t     head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic signed [15:0] sample,
    output logic [2:0]         status,
    output logic [15:0]        channel_count,
    output logic [31:0]        rate_hz,
    output logic               last
);
    import wpp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t item_reg;

    // advance when the output register is empty or its transfer completes
    assign pop        = head.valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);

    assign out_valid     = valid_reg;
    assign kind          = item_reg.kind;
    assign sample        = item_reg.sample;
    assign status        = item_reg.status;
    assign channel_count = item_reg.channel_count;
    assign rate_hz       = item_reg.rate_hz;
    assign last          = (item_reg.kind == KIND_REPORT);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule
